>>> design/sim_pkg.sv
// Shared types and constants for the sorted interval insert/merge block.
// No dependencies; imported by sim_cell and sorted_interval_insert_merge.
package sim_pkg;

    localparam int DATA_W = 32;

    // Opcodes of an input transfer
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // One closed interval [lo, hi]
    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } entry_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

>>> design/sorted_interval_insert_merge.sv
// Top level: sequencer plus a ring of sim_cell entries, and the result register.
// Depends on sim_pkg and sim_cell.
// Clear and append: one status result in the cycle after the transfer; busy stays low.
// Insert: a scan pass over all TABLE_DEPTH cells builds the merged interval, an emit pass over
//   them (pausing where the merged slot falls inside it), then the closing states S_END and
//   S_FLUSH; the last result appears in the same cycle that busy drops.
// Results come one per cycle at most on out_valid; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the table and returns the sequencer to idle.
module sorted_interval_insert_merge
    import sim_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] bound_low,
    input  logic signed [DATA_W-1:0] bound_high,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_low,
    output logic signed [DATA_W-1:0] out_high,
    output logic                     status,
    output logic                     last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_END   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic          placed_reg, placed_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;
    entry_t        new_reg, new_next;
    entry_t        merge_reg, merge_next;
    entry_t        pend_reg, pend_next;
    entry_t        out_reg, out_next;
    logic          status_reg, status_next;
    logic          last_reg, last_next;

    entry_t        cell_q [TABLE_DEPTH];
    entry_t        head;
    entry_t        in_entry;
    entry_t        push_data;
    logic          push;
    logic          shift;
    logic          load;
    logic          accept;
    logic          in_range;
    logic          overlap;
    logic          last_step;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign head      = cell_q[0];
    assign in_entry  = '{lo: bound_low, hi: bound_high};
    assign in_range  = (step_reg < count_reg);
    assign overlap   = (new_reg.lo <= head.hi) && (head.lo <= new_reg.hi);
    assign last_step = (step_reg == CW'(TABLE_DEPTH - 1));

    // Ring of cells; cell 0 is the head, each cell takes its upper neighbor's entry
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     nbr;

        assign ctrl.shift = shift;
        assign ctrl.load  = load && (count_reg == CW'(i));
        assign nbr        = cell_q[(i + 1) % TABLE_DEPTH];

        sim_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .shift_in  (nbr),
            .load_data (in_entry),
            .data      (cell_q[i])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        placed_next     = placed_reg;
        new_next        = new_reg;
        merge_next      = merge_reg;
        push            = 1'b0;
        push_data       = head;
        shift           = 1'b0;
        load            = 1'b0;
        out_valid_next  = 1'b0;
        out_next        = '0;
        status_next     = ST_OK;
        last_next       = 1'b1;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (opcode == OP_CLEAR)
                    begin
                        count_next     = '0;
                        out_valid_next = 1'b1;
                    end
                    else if (opcode == OP_APPEND)
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            load       = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (opcode == OP_INSERT)
                    begin
                        new_next    = in_entry;
                        merge_next  = in_entry;
                        step_next   = '0;
                        placed_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Pass one: widen the merged interval over every overlapping entry
            S_SCAN:
            begin
                shift = 1'b1;
                if (in_range && overlap)
                begin
                    if (head.lo <= merge_reg.lo)
                    begin
                        merge_next.lo = head.lo;
                    end
                    if (merge_reg.hi <= head.hi)
                    begin
                        merge_next.hi = head.hi;
                    end
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = S_EMIT;
                end
            end

            // Pass two: emit kept entries, slot the merged one in before the first above it
            S_EMIT:
            begin
                if (in_range && !overlap && !placed_reg && !(head.lo <= merge_reg.hi))
                begin
                    push        = 1'b1;
                    push_data   = merge_reg;
                    placed_next = 1'b1;
                end
                else
                begin
                    push      = in_range && !overlap;
                    push_data = head;
                    shift     = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (last_step)
                    begin
                        step_next  = '0;
                        state_next = S_END;
                    end
                end
            end

            S_END:
            begin
                if (!placed_reg)
                begin
                    push        = 1'b1;
                    push_data   = merge_reg;
                    placed_next = 1'b1;
                end
                state_next = S_FLUSH;
            end

            // Held result goes out marked last
            S_FLUSH:
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                last_next       = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // One-deep hold so the final result of an insert can be marked last
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                last_next      = 1'b0;
            end
            pend_next       = push_data;
            pend_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            placed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            placed_reg     <= placed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        merge_reg  <= merge_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_low   = out_reg.lo;
    assign out_high  = out_reg.hi;
    assign status    = status_reg;
    assign last      = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && out_low == '0 && out_high == '0)
        else $error("full status result malformed");

    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_INSERT |=> busy)
        else $error("insert did not start a walk");

    a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |=> out_valid && last && !busy)
        else $error("insert did not end with a last result");

    a_pend_at_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> pend_valid_reg)
        else $error("nothing held for the final result");

endmodule

>>> design/sim_cell.sv
// One storage cell of the interval ring: holds a single table entry.
// Depends on sim_pkg (entry_t, cell_ctrl_t).
module sim_cell
    import sim_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     shift_in,
    input  entry_t     load_data,
    output entry_t     data
);

    entry_t data_reg;
    entry_t data_next;

    // Load from the append path, otherwise take the neighbor's entry when rotating
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
